FILE: sv/button_debounce_longpress_macros.svh
// assertion macros for the button debounce block
// used by the top level; expects clk and rst_n in scope
`ifndef BUTTON_DEBOUNCE_LONGPRESS_MACROS_SVH
`define BUTTON_DEBOUNCE_LONGPRESS_MACROS_SVH

// same-cycle implication, off during reset
`define BDLP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("button debounce check failed");

// next-cycle implication, off during reset
`define BDLP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("button debounce check failed");

`endif

FILE: sv/bdlp_pkg.sv
// shared types and constants for the button debounce block
// no dependencies
package bdlp_pkg;

  localparam int unsigned TIME_W  = 32;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned CFG_IDX_W = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE     = 2'd2;

  // register reset values
  localparam logic [CFG_W-1:0] DEBOUNCE_RST   = 16'd50;
  localparam logic [CFG_W-1:0] LONG_PRESS_RST = 16'd1000;
  localparam logic             ACTIVE_RST     = 1'b0;

  typedef enum logic [1:0] {
    PH_STANDBY  = 2'd0,
    PH_PRESSED  = 2'd1,
    PH_PRESSING = 2'd2,
    PH_RELEASED = 2'd3
  } phase_t;

  typedef struct packed {
    logic [CFG_W-1:0] debounce_ms;
    logic [CFG_W-1:0] long_press_ms;
    logic             active_level;
  } cfg_t;

  typedef struct packed {
    phase_t            phase;
    logic [TIME_W-1:0] next_sample_ms;
    logic [TIME_W-1:0] press_start_ms;
    logic              long_reported;
  } state_t;

  typedef struct packed {
    logic   ev_pressed;
    logic   ev_pressing;
    logic   ev_long_press;
    logic   ev_released;
    logic   ev_clicked;
    phase_t phase;
  } result_t;

endpackage

FILE: sv/bdlp_channels.sv
// valid/ready channel interfaces for the button debounce block
// depends on bdlp_pkg
interface bdlp_in_if;
  logic                           valid;
  logic                           ready;
  logic [bdlp_pkg::TIME_W-1:0]    now_ms;
  logic                           pin_level;

  modport source (output valid, output now_ms, output pin_level, input ready);
  modport sink   (input valid, input now_ms, input pin_level, output ready);
endinterface

interface bdlp_out_if;
  logic       valid;
  logic       ready;
  logic       ev_pressed;
  logic       ev_pressing;
  logic       ev_long_press;
  logic       ev_released;
  logic       ev_clicked;
  logic [1:0] phase;

  modport source (output valid, output ev_pressed, output ev_pressing,
                  output ev_long_press, output ev_released, output ev_clicked,
                  output phase, input ready);
  modport sink   (input valid, input ev_pressed, input ev_pressing,
                  input ev_long_press, input ev_released, input ev_clicked,
                  input phase, output ready);
endinterface

interface bdlp_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [bdlp_pkg::CFG_IDX_W-1:0]   index;
  logic [bdlp_pkg::CFG_W-1:0]       data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: sv/bdlp_step.sv
// next-state and event logic for one poll of the debounce machine
// depends on bdlp_pkg
module bdlp_step (
  input  bdlp_pkg::cfg_t                  cfg,
  input  bdlp_pkg::state_t                state,
  input  logic [bdlp_pkg::TIME_W-1:0]     now_ms,
  input  logic                            pin_level,
  output bdlp_pkg::state_t                state_nxt,
  output bdlp_pkg::result_t               res
);

  logic                          held;
  logic                          sample_due;
  logic                          long_due;
  logic [bdlp_pkg::TIME_W-1:0]   rearm_ms;
  logic [bdlp_pkg::TIME_W-1:0]   long_at_ms;

  // level compare and time sums, all modulo 2^32
  assign held       = (pin_level == cfg.active_level);
  assign sample_due = (now_ms >= state.next_sample_ms);
  assign rearm_ms   = now_ms + bdlp_pkg::TIME_W'(cfg.debounce_ms);
  assign long_at_ms = state.press_start_ms + bdlp_pkg::TIME_W'(cfg.long_press_ms);
  assign long_due   = !state.long_reported && (long_at_ms <= now_ms);

  // phase machine
  always_comb begin
    state_nxt = state;
    res       = '0;
    priority if (state.phase == bdlp_pkg::PH_RELEASED) begin
      state_nxt.next_sample_ms = rearm_ms;
      state_nxt.phase          = bdlp_pkg::PH_STANDBY;
    end else if (sample_due) begin
      state_nxt.next_sample_ms = rearm_ms;
      unique case (state.phase)
        bdlp_pkg::PH_STANDBY: begin
          if (held) begin
            state_nxt.phase          = bdlp_pkg::PH_PRESSED;
            state_nxt.press_start_ms = now_ms;
            state_nxt.long_reported  = 1'b0;
            res.ev_pressed           = 1'b1;
          end
        end
        bdlp_pkg::PH_PRESSED, bdlp_pkg::PH_PRESSING: begin
          if (held) begin
            res.ev_pressing = 1'b1;
            // long press only from the held phase, once per hold
            if (state.phase == bdlp_pkg::PH_PRESSING && long_due) begin
              res.ev_long_press       = 1'b1;
              state_nxt.long_reported = 1'b1;
            end
            state_nxt.phase = bdlp_pkg::PH_PRESSING;
          end else begin
            state_nxt.phase         = bdlp_pkg::PH_RELEASED;
            state_nxt.long_reported = 1'b0;
            res.ev_released         = 1'b1;
            res.ev_clicked          = 1'b1;
          end
        end
        bdlp_pkg::PH_RELEASED: begin
          // handled above
        end
      endcase
    end else begin
      // sample time not reached yet, state holds
    end
    res.phase = state_nxt.phase;
  end

endmodule

FILE: sv/button_debounce_longpress.sv
// Button debounce with long-press detection, one poll word in, one event word out.
// Accepted words go to the input register, then their results to the output register.
// Throughput: one word per cycle unless the output stalls; next state is combinational.
// An input register and an output register decouple the two sides under stall.
// Reset (synchronous, active low): phase released, times cleared, registers to defaults.
`include "button_debounce_longpress_macros.svh"

module button_debounce_longpress (
  input  logic       clk,
  input  logic       rst_n,
  bdlp_in_if.sink    in_ch,
  bdlp_out_if.source out_ch,
  bdlp_cfg_if.sink   cfg_ch
);

  bdlp_pkg::cfg_t                cfg_r;
  bdlp_pkg::state_t              state_r;
  bdlp_pkg::state_t              state_nxt;
  bdlp_pkg::result_t             res_nxt;
  bdlp_pkg::result_t             out_r;
  logic                          out_valid_r;
  logic                          s1_valid_r;
  logic [bdlp_pkg::TIME_W-1:0]   s1_now_r;
  logic                          s1_pin_r;
  logic                          advance;
  logic                          in_accept;

  // handshake: the input stage moves on when the output stage is free or draining
  assign advance      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !s1_valid_r || advance;
  assign in_accept    = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ms   <= bdlp_pkg::DEBOUNCE_RST;
      cfg_r.long_press_ms <= bdlp_pkg::LONG_PRESS_RST;
      cfg_r.active_level  <= bdlp_pkg::ACTIVE_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        bdlp_pkg::CFG_DEBOUNCE:   cfg_r.debounce_ms   <= cfg_ch.data;
        bdlp_pkg::CFG_LONG_PRESS: cfg_r.long_press_ms <= cfg_ch.data;
        bdlp_pkg::CFG_ACTIVE:     cfg_r.active_level  <= cfg_ch.data[0];
        default: begin
          // unknown index, write dropped
        end
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_now_r <= in_ch.now_ms;
      s1_pin_r <= in_ch.pin_level;
    end
  end

  bdlp_step u_step (
    .cfg       (cfg_r),
    .state     (state_r),
    .now_ms    (s1_now_r),
    .pin_level (s1_pin_r),
    .state_nxt (state_nxt),
    .res       (res_nxt)
  );

  // machine state, updated as each word passes to the output
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase          <= bdlp_pkg::PH_RELEASED;
      state_r.next_sample_ms <= '0;
      state_r.press_start_ms <= '0;
      state_r.long_reported  <= 1'b0;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_r <= res_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.ev_pressed    = out_r.ev_pressed;
  assign out_ch.ev_pressing   = out_r.ev_pressing;
  assign out_ch.ev_long_press = out_r.ev_long_press;
  assign out_ch.ev_released   = out_r.ev_released;
  assign out_ch.ev_clicked    = out_r.ev_clicked;
  assign out_ch.phase         = out_r.phase;

  // checks
  `BDLP_ASSERT_IMP(a_long_only_held, state_r.long_reported,
                   state_r.phase == bdlp_pkg::PH_PRESSING)
  `BDLP_ASSERT_IMP(a_long_with_pressing, out_valid_r && out_r.ev_long_press,
                   out_r.ev_pressing && out_r.phase == bdlp_pkg::PH_PRESSING)
  `BDLP_ASSERT_IMP(a_release_click, out_valid_r && out_r.ev_released,
                   out_r.ev_clicked && out_r.phase == bdlp_pkg::PH_RELEASED)
  `BDLP_ASSERT_IMP(a_no_overrun, s1_valid_r && !advance, !in_accept)
  `BDLP_ASSERT_NXT(a_state_holds, !advance, $stable(state_r))

endmodule
